>>> hw/rtl/afns_pkg.sv
// Shared types and constants for the aspect-fit scaler address unit.
package afns_pkg;

   localparam int CFG_W      = 13;
   localparam int COLOR_W    = 32;
   localparam int COORD_W    = 12;
   localparam int INDEX_W    = 24;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 80;

   localparam logic [CFG_W-1:0]   RESET_DEST_WIDTH  = 13'd640;
   localparam logic [CFG_W-1:0]   RESET_DEST_HEIGHT = 13'd480;
   localparam logic [CFG_W-1:0]   RESET_SRC_WIDTH   = 13'd640;
   localparam logic [CFG_W-1:0]   RESET_SRC_HEIGHT  = 13'd480;
   localparam logic [COLOR_W-1:0] RESET_BACKGROUND  = 32'd0;

   typedef enum logic [2:0] {
      REG_DEST_WIDTH  = 3'd0,
      REG_DEST_HEIGHT = 3'd1,
      REG_SRC_WIDTH   = 3'd2,
      REG_SRC_HEIGHT  = 3'd3,
      REG_BACKGROUND  = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [CFG_W-1:0]   dest_width;
      logic [CFG_W-1:0]   dest_height;
      logic [CFG_W-1:0]   src_width;
      logic [CFG_W-1:0]   src_height;
      logic [COLOR_W-1:0] background_color;
   } cfg_type;

endpackage

>>> hw/rtl/aspect_fit_nearest_scaler_address.sv
// Aspect-fit nearest-neighbour scaler address unit, top level.
//
// req channel: one destination pixel per item (dest_x, dest_y).
// rsp channel: one item per request, in order: background flag on tuser,
//   source column, row, linear source index and fill colour on tdata.
// csr port: APB-style registers dest_width, dest_height, src_width,
//   src_height, background_color at byte addresses 0, 4, 8, 12, 16.
// Throughput: one item per cycle while setup is done and rsp_tready
//   does not stall. Each item passes through six register stages
//   (offset, scale multiply, reciprocal multiply, back multiply,
//   correction, index multiply-add).
// After reset and after every register write the fit geometry and two
//   reciprocals are recomputed on a shared bit-serial divider, three
//   divisions of 2*W+1 steps, W = $clog2(MAX_DIM+1). req_tready stays
//   low meanwhile.
// A stalled rsp_tready holds the output item and fills the stages behind
//   it; req_tready drops once all six hold an item.
module aspect_fit_nearest_scaler_address
   import afns_pkg::*;
#(
   parameter int MAX_DIM = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // dest_x, dest_y
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // source_x, source_y, source_index, fill_color
   output logic                  rsp_tuser,   // is_background
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int RW = 2 * DW + 1;

   cfg_type            cfg;
   logic               cfg_write;
   logic               geom_ready;
   logic [DW-1:0]      sw, sh, fw, fh, ox, oy;
   logic [DW:0]        ex, ey;
   logic [RW-1:0]      rx, ry;
   logic [COORD_W-1:0] sx, sy;
   logic [INDEX_W-1:0] index;
   logic [COLOR_W-1:0] fill;

   afns_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .cfg_write   (cfg_write)
   );

   afns_setup #(.MAX_DIM(MAX_DIM)) u_setup (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cfg_write  (cfg_write),
      .geom_ready (geom_ready),
      .sw (sw), .sh (sh), .fw (fw), .fh (fh),
      .ox (ox), .oy (oy), .ex (ex), .ey (ey),
      .rx (rx), .ry (ry)
   );

   afns_pipe #(.MAX_DIM(MAX_DIM)) u_pipe (
      .clock      (clock),
      .reset      (reset),
      .geom_ready (geom_ready),
      .sw (sw), .sh (sh), .fw (fw), .fh (fh),
      .ox (ox), .oy (oy), .ex (ex), .ey (ey),
      .rx (rx), .ry (ry),
      .color      (cfg.background_color),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_x       (req_tdata[COORD_W-1:0]),
      .in_y       (req_tdata[2*COORD_W-1:COORD_W]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_bg     (rsp_tuser),
      .out_sx     (sx),
      .out_sy     (sy),
      .out_index  (index),
      .out_fill   (fill)
   );

   assign rsp_tdata = {fill, index, sy, sx};

endmodule

>>> hw/rtl/afns_csr.sv
// Configuration register file with APB-style access.
module afns_csr
   import afns_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg,
   output logic                  cfg_write
);

   cfg_type       cfg_ff;
   reg_index_type index;

   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_width       <= RESET_DEST_WIDTH;
         cfg_ff.dest_height      <= RESET_DEST_HEIGHT;
         cfg_ff.src_width        <= RESET_SRC_WIDTH;
         cfg_ff.src_height       <= RESET_SRC_HEIGHT;
         cfg_ff.background_color <= RESET_BACKGROUND;
      end else if (cfg_write) begin
         unique case (index)
            REG_DEST_WIDTH:  cfg_ff.dest_width       <= csr_pwdata[CFG_W-1:0];
            REG_DEST_HEIGHT: cfg_ff.dest_height      <= csr_pwdata[CFG_W-1:0];
            REG_SRC_WIDTH:   cfg_ff.src_width        <= csr_pwdata[CFG_W-1:0];
            REG_SRC_HEIGHT:  cfg_ff.src_height       <= csr_pwdata[CFG_W-1:0];
            REG_BACKGROUND:  cfg_ff.background_color <= csr_pwdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_DEST_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.dest_width);
         REG_DEST_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.dest_height);
         REG_SRC_WIDTH:   csr_prdata = CSR_DATA_W'(cfg_ff.src_width);
         REG_SRC_HEIGHT:  csr_prdata = CSR_DATA_W'(cfg_ff.src_height);
         REG_BACKGROUND:  csr_prdata = CSR_DATA_W'(cfg_ff.background_color);
         default:         csr_prdata = '0;
      endcase
   end

endmodule

>>> hw/rtl/afns_div.sv
// Restoring divider, one quotient bit per cycle.
module afns_div #(
   parameter int DVW = 27,
   parameter int DSW = 13
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [DVW-1:0] dividend,
   input  logic [DSW-1:0] divisor,
   output logic [DVW-1:0] quotient,
   output logic           done
);

   localparam int CW = $clog2(DVW + 1);

   logic           busy_ff;
   logic           done_ff;
   logic [CW-1:0]  cnt_ff;
   logic [DVW-1:0] quo_ff;
   logic [DSW-1:0] rem_ff;
   logic [DSW-1:0] dsr_ff;
   logic [DSW:0]   shifted;
   logic           ge;
   logic [DSW-1:0] rem_in;
   logic [DVW-1:0] quo_in;

   always_comb begin
      shifted = {rem_ff, quo_ff[DVW-1]};
      ge      = shifted >= {1'b0, dsr_ff};
      rem_in  = ge ? DSW'(shifted - {1'b0, dsr_ff}) : DSW'(shifted);
      quo_in  = {quo_ff[DVW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CW'(DVW);
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 1'b1;
         busy_ff <= cnt_ff != CW'(1);
         done_ff <= cnt_ff == CW'(1);
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

>>> hw/rtl/afns_setup.sv
// Fit geometry and reciprocal sequencer, rerun after reset and each register write.
module afns_setup
   import afns_pkg::*;
#(
   parameter int MAX_DIM = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cfg_type                            cfg,
   input  logic                               cfg_write,
   output logic                               geom_ready,
   output logic [$clog2(MAX_DIM+1)-1:0]       sw,
   output logic [$clog2(MAX_DIM+1)-1:0]       sh,
   output logic [$clog2(MAX_DIM+1)-1:0]       fw,
   output logic [$clog2(MAX_DIM+1)-1:0]       fh,
   output logic [$clog2(MAX_DIM+1)-1:0]       ox,
   output logic [$clog2(MAX_DIM+1)-1:0]       oy,
   output logic [$clog2(MAX_DIM+1):0]         ex,
   output logic [$clog2(MAX_DIM+1):0]         ey,
   output logic [2*$clog2(MAX_DIM+1):0]       rx,
   output logic [2*$clog2(MAX_DIM+1):0]       ry
);

   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int NW = 2 * DW;
   localparam int RW = NW + 1;
   localparam logic [RW-1:0] ONE_K = RW'(1) << NW;

   typedef enum logic [2:0] {
      ST_START, ST_FIT_GO, ST_FIT, ST_EDGE, ST_RECX, ST_RECY, ST_DONE
   } state_type;

   function automatic logic [DW-1:0] eff(input logic [CFG_W-1:0] v);
      logic [31:0] w;
      begin
         w = 32'(v);
         if (w == 32'd0) w = 32'd1;
         else if (w > 32'(MAX_DIM)) w = 32'(MAX_DIM);
         return DW'(w);
      end
   endfunction

   state_type      state_ff;
   logic           ready_ff;
   logic           start_ff;
   logic           wb_ff;
   logic [NW-1:0]  p1_ff, p2_ff;
   logic [RW-1:0]  dvd_ff;
   logic [DW-1:0]  dsr_ff;
   logic [DW-1:0]  dw_ff, dh_ff, sw_ff, sh_ff, fw_ff, fh_ff, ox_ff, oy_ff;
   logic [DW:0]    ex_ff, ey_ff;
   logic [RW-1:0]  rx_ff, ry_ff;
   logic [RW-1:0]  quo;
   logic           div_done;
   logic           fin;
   logic [DW-1:0]  q_fit;
   logic [DW-1:0]  ox_in, oy_in;

   afns_div #(.DVW(RW), .DSW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (dvd_ff),
      .divisor  (dsr_ff),
      .quotient (quo),
      .done     (div_done)
   );

   always_comb begin
      fin   = div_done & ~start_ff;
      q_fit = (quo[DW-1:0] == '0) ? DW'(1) : quo[DW-1:0];
      ox_in = (dw_ff > fw_ff) ? DW'((dw_ff - fw_ff) >> 1) : '0;
      oy_in = (dh_ff > fh_ff) ? DW'((dh_ff - fh_ff) >> 1) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
         ready_ff <= 1'b0;
         start_ff <= 1'b0;
      end else if (cfg_write) begin
         state_ff <= ST_START;
         ready_ff <= 1'b0;
         start_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         unique case (state_ff)
            ST_START: begin
               dw_ff    <= eff(cfg.dest_width);
               dh_ff    <= eff(cfg.dest_height);
               sw_ff    <= eff(cfg.src_width);
               sh_ff    <= eff(cfg.src_height);
               p1_ff    <= NW'(eff(cfg.dest_width) * eff(cfg.src_height));
               p2_ff    <= NW'(eff(cfg.dest_height) * eff(cfg.src_width));
               state_ff <= ST_FIT_GO;
            end
            ST_FIT_GO: begin
               wb_ff    <= p1_ff < p2_ff;
               dvd_ff   <= RW'((p1_ff < p2_ff) ? p1_ff : p2_ff);
               dsr_ff   <= (p1_ff < p2_ff) ? sw_ff : sh_ff;
               start_ff <= 1'b1;
               state_ff <= ST_FIT;
            end
            ST_FIT: begin
               if (fin) begin
                  fw_ff    <= wb_ff ? dw_ff : q_fit;
                  fh_ff    <= wb_ff ? q_fit : dh_ff;
                  state_ff <= ST_EDGE;
               end
            end
            ST_EDGE: begin
               ox_ff    <= ox_in;
               oy_ff    <= oy_in;
               ex_ff    <= {1'b0, ox_in} + {1'b0, fw_ff};
               ey_ff    <= {1'b0, oy_in} + {1'b0, fh_ff};
               dvd_ff   <= ONE_K;
               dsr_ff   <= fw_ff;
               start_ff <= 1'b1;
               state_ff <= ST_RECX;
            end
            ST_RECX: begin
               if (fin) begin
                  rx_ff    <= quo;
                  dvd_ff   <= ONE_K;
                  dsr_ff   <= fh_ff;
                  start_ff <= 1'b1;
                  state_ff <= ST_RECY;
               end
            end
            ST_RECY: begin
               if (fin) begin
                  ry_ff    <= quo;
                  ready_ff <= 1'b1;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: ;
            default: state_ff <= ST_START;
         endcase
      end
   end

   assign geom_ready = ready_ff;
   assign sw = sw_ff;
   assign sh = sh_ff;
   assign fw = fw_ff;
   assign fh = fh_ff;
   assign ox = ox_ff;
   assign oy = oy_ff;
   assign ex = ex_ff;
   assign ey = ey_ff;
   assign rx = rx_ff;
   assign ry = ry_ff;

endmodule

>>> hw/rtl/afns_pipe.sv
// Six-stage per-pixel address pipeline.
module afns_pipe
   import afns_pkg::*;
#(
   parameter int MAX_DIM = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          geom_ready,
   input  logic [$clog2(MAX_DIM+1)-1:0]  sw,
   input  logic [$clog2(MAX_DIM+1)-1:0]  sh,
   input  logic [$clog2(MAX_DIM+1)-1:0]  fw,
   input  logic [$clog2(MAX_DIM+1)-1:0]  fh,
   input  logic [$clog2(MAX_DIM+1)-1:0]  ox,
   input  logic [$clog2(MAX_DIM+1)-1:0]  oy,
   input  logic [$clog2(MAX_DIM+1):0]    ex,
   input  logic [$clog2(MAX_DIM+1):0]    ey,
   input  logic [2*$clog2(MAX_DIM+1):0]  rx,
   input  logic [2*$clog2(MAX_DIM+1):0]  ry,
   input  logic [COLOR_W-1:0]            color,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [COORD_W-1:0]            in_x,
   input  logic [COORD_W-1:0]            in_y,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic                          out_bg,
   output logic [COORD_W-1:0]            out_sx,
   output logic [COORD_W-1:0]            out_sy,
   output logic [INDEX_W-1:0]            out_index,
   output logic [COLOR_W-1:0]            out_fill
);

   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int NW = 2 * DW;
   localparam int RW = NW + 1;
   localparam int CW = ((DW > COORD_W) ? DW : COORD_W) + 1;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic adv1, adv2, adv3, adv4, adv5, adv6;

   logic              bg1_ff, bg2_ff, bg3_ff, bg4_ff, bg5_ff, bg6_ff;
   logic [DW-1:0]     dx1_ff, dy1_ff;
   logic [NW-1:0]     nx2_ff, ny2_ff, nx3_ff, ny3_ff, nx4_ff, ny4_ff;
   logic [DW-1:0]     qx3_ff, qy3_ff, qx4_ff, qy4_ff;
   logic [NW-1:0]     mx4_ff, my4_ff;
   logic [DW-1:0]     sx5_ff, sy5_ff;
   logic [COORD_W-1:0] sx6_ff, sy6_ff;
   logic [INDEX_W-1:0] idx6_ff;

   logic [CW-1:0]     xe, ye;
   logic              in_rect;
   logic [NW+RW-1:0]  px, py;
   logic [DW:0]       cx, cy;
   logic [DW-1:0]     sx_in, sy_in;
   logic [NW:0]       idx_in;

   assign adv6     = ~v6_ff | out_ready;
   assign adv5     = ~v5_ff | adv6;
   assign adv4     = ~v4_ff | adv5;
   assign adv3     = ~v3_ff | adv4;
   assign adv2     = ~v2_ff | adv3;
   assign adv1     = ~v1_ff | adv2;
   assign in_ready = geom_ready & adv1;

   always_comb begin
      xe      = CW'(in_x);
      ye      = CW'(in_y);
      in_rect = (xe >= CW'(ox)) && (xe < CW'(ex)) && (ye >= CW'(oy)) && (ye < CW'(ey));
      px      = nx2_ff * rx;
      py      = ny2_ff * ry;
      cx      = (nx4_ff - mx4_ff >= NW'(fw)) ? {1'b0, qx4_ff} + 1'b1 : {1'b0, qx4_ff};
      cy      = (ny4_ff - my4_ff >= NW'(fh)) ? {1'b0, qy4_ff} + 1'b1 : {1'b0, qy4_ff};
      sx_in   = (cx >= {1'b0, sw}) ? sw - 1'b1 : cx[DW-1:0];
      sy_in   = (cy >= {1'b0, sh}) ? sh - 1'b1 : cy[DW-1:0];
      idx_in  = (NW+1)'(sy5_ff * sw) + (NW+1)'(sx5_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         {v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff} <= '0;
      end else begin
         if (adv1) v1_ff <= in_valid & in_ready;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
         if (adv5) v5_ff <= v4_ff;
         if (adv6) v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         bg1_ff <= ~in_rect;
         dx1_ff <= DW'(xe - CW'(ox));
         dy1_ff <= DW'(ye - CW'(oy));
      end
      if (adv2) begin
         bg2_ff <= bg1_ff;
         nx2_ff <= NW'(dx1_ff * sw);
         ny2_ff <= NW'(dy1_ff * sh);
      end
      if (adv3) begin
         bg3_ff <= bg2_ff;
         nx3_ff <= nx2_ff;
         ny3_ff <= ny2_ff;
         qx3_ff <= px[NW +: DW];
         qy3_ff <= py[NW +: DW];
      end
      if (adv4) begin
         bg4_ff <= bg3_ff;
         nx4_ff <= nx3_ff;
         ny4_ff <= ny3_ff;
         qx4_ff <= qx3_ff;
         qy4_ff <= qy3_ff;
         mx4_ff <= NW'(qx3_ff * fw);
         my4_ff <= NW'(qy3_ff * fh);
      end
      if (adv5) begin
         bg5_ff <= bg4_ff;
         sx5_ff <= sx_in;
         sy5_ff <= sy_in;
      end
      if (adv6) begin
         bg6_ff  <= bg5_ff;
         sx6_ff  <= bg5_ff ? '0 : COORD_W'(sx5_ff);
         sy6_ff  <= bg5_ff ? '0 : COORD_W'(sy5_ff);
         idx6_ff <= bg5_ff ? '0 : INDEX_W'(idx_in);
      end
   end

   assign out_valid = v6_ff;
   assign out_bg    = bg6_ff;
   assign out_sx    = sx6_ff;
   assign out_sy    = sy6_ff;
   assign out_index = idx6_ff;
   assign out_fill  = bg6_ff ? color : '0;

endmodule

>>> hw/rtl/afns_checker.sv
// Port-level assertions for the scaler address unit, with bind.
module afns_checker
   import afns_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   a_bg_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[47:0] == 48'd0)
      else $error("background item carries a source address");

   a_fg_zero_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[79:48] == 32'd0)
      else $error("image item carries a fill colour");

   a_setup_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_tready)
      else $error("item taken before geometry setup");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled item changed");

endmodule

bind aspect_fit_nearest_scaler_address afns_checker u_afns_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
